// ----- src/decode_stage_with_scoreboard_assert.svh -----
// Assertion macros for the decode stage with scoreboard.
`ifndef DECODE_STAGE_WITH_SCOREBOARD_ASSERT_SVH
`define DECODE_STAGE_WITH_SCOREBOARD_ASSERT_SVH

`ifndef SYNTH

// Clocked check that is switched off while reset is asserted.
`define DSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define DSS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DSS_ASSERT(label, prop, msg)
`define DSS_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- src/dss_pkg.sv -----
// Shared types and constants for the decode stage with scoreboard.
package dss_pkg;

    localparam int PENDING_MAX_DEF = 7;
    localparam int NUM_REGS        = 32;
    localparam int REG_W           = 5;
    localparam int OPCODE_W        = 6;
    localparam int WORD_W          = 32;
    localparam int SHAMT_W         = 5;
    localparam int IMM_W           = 16;
    localparam int TARGET_W        = 26;

    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 160;
    localparam int M_TUSER_W = 2;

    // Opcode landmarks of the instruction set.
    localparam logic [OPCODE_W-1:0] OP_R_LAST     = 6'b010110;
    localparam logic [OPCODE_W-1:0] OP_I_LAST     = 6'b101110;
    localparam logic [OPCODE_W-1:0] OP_JUMP       = 6'b101111;
    localparam logic [OPCODE_W-1:0] OP_R_NO_WB0   = 6'b001110;
    localparam logic [OPCODE_W-1:0] OP_R_NO_WB1   = 6'b001111;
    localparam logic [OPCODE_W-1:0] OP_STORE      = 6'b011111;
    localparam logic [OPCODE_W-1:0] OP_I_WB_LIMIT = 6'b100010;
    localparam logic [OPCODE_W-1:0] OP_BRANCH0    = 6'b100011;
    localparam logic [OPCODE_W-1:0] OP_BRANCH1    = 6'b100100;
    localparam logic [OPCODE_W-1:0] OP_BRANCH2    = 6'b100111;
    localparam logic [OPCODE_W-1:0] OP_BRANCH3    = 6'b101000;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_NOOP   = 2'd1,
        ACT_DECODE = 2'd2
    } action_t;

    // Held decoded record.
    typedef struct packed {
        logic [TARGET_W-1:0] target_address;
        logic [WORD_W-1:0]   rd_value;
        logic [IMM_W-1:0]    immediate;
        logic [SHAMT_W-1:0]  shift_amount;
        logic [WORD_W-1:0]   operand_two;
        logic [WORD_W-1:0]   operand_one;
        logic [REG_W-1:0]    destination;
        logic [OPCODE_W-1:0] opcode;
    } record_t;

    // Registers named by the word under decode.
    typedef struct packed {
        logic [REG_W-1:0] reg_a;
        logic [REG_W-1:0] reg_b;
        logic [REG_W-1:0] reg_c;
    } sb_check_t;

    // Scoreboard update for one beat; at most one of the two is set.
    typedef struct packed {
        logic             mark_en;
        logic [REG_W-1:0] mark_reg;
        logic             retire_en;
        logic [REG_W-1:0] retire_reg;
    } sb_ctrl_t;

endpackage

// ----- src/dss_scoreboard.sv -----
// Per-register scoreboard of pending writes with saturating counters.
module dss_scoreboard
    import dss_pkg::*;
#(
    parameter int PENDING_MAX = PENDING_MAX_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  sb_check_t check,
    input  sb_ctrl_t  ctrl,
    output logic      dep
);

    localparam int CNT_W = $clog2(PENDING_MAX + 1);

    logic [CNT_W-1:0]    count_reg  [NUM_REGS];
    logic [CNT_W-1:0]    count_next [NUM_REGS];
    logic [NUM_REGS-1:0] pending;
    logic [NUM_REGS-1:0] named;

    // Each counter is its own cell; the named registers are matched by decoding.
    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            pending[i]    = (count_reg[i] != '0);
            named[i]      = (check.reg_a == REG_W'(i)) || (check.reg_b == REG_W'(i)) ||
                            (check.reg_c == REG_W'(i));
            count_next[i] = count_reg[i];
            if (ctrl.mark_en && (ctrl.mark_reg == REG_W'(i)) &&
                (count_reg[i] < CNT_W'(PENDING_MAX)))
            begin
                count_next[i] = count_reg[i] + CNT_W'(1);
            end
            else if (ctrl.retire_en && (ctrl.retire_reg == REG_W'(i)) && pending[i])
            begin
                count_next[i] = count_reg[i] - CNT_W'(1);
            end
        end
    end

    assign dep = |(pending & named);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

// ----- src/decode_stage_with_scoreboard.sv -----
// Top level of the pipeline decode stage with a pending-write scoreboard.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  instruction, register values, retire command
//  m_*      out        m_tvalid/m_tready  action, stall flag and held decoded record
//
// One beat is taken per clock while s_tready is high. A beat is held in the input
// register and is decoded on its way into the result register, where its result is
// presented; the scoreboard update and the dependency check meet in that single
// stage.
// Reset clears the scoreboard counters, the held record, the stall flag and both
// valid flags. While m_tready is low the result holds and the input register still
// takes one more beat; s_tready follows m_tready when both registers are full.
`include "decode_stage_with_scoreboard_assert.svh"

module decode_stage_with_scoreboard
    import dss_pkg::*;
#(
    parameter int PENDING_MAX = PENDING_MAX_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // instruction[31:0], exec_blocked[32], retire_reg[37:33], value_field_a[69:38],
    // value_field_b[101:70], value_field_c[133:102], zero pad[135:134]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd[0], noop_in[1]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // stalled[0], opcode[6:1], destination[11:7], operand_one[43:12],
    // operand_two[75:44], shift_amount[80:76], immediate[96:81],
    // rd_value[128:97], target_address[154:129], zero pad[159:155]
    output logic [M_TDATA_W-1:0] m_tdata,
    // action[1:0]
    output logic [M_TUSER_W-1:0] m_tuser
);

    // Input register. Payload carries no reset.
    logic               in_valid_reg;
    logic               in_cmd_reg;
    logic               in_noop_reg;
    logic               in_eblk_reg;
    logic [WORD_W-1:0]  in_word_reg;
    logic [REG_W-1:0]   in_retire_reg;
    logic [WORD_W-1:0]  in_va_reg;
    logic [WORD_W-1:0]  in_vb_reg;
    logic [WORD_W-1:0]  in_vc_reg;

    // Result register. The held record and the stall flag only change when a beat
    // moves into the result register, so they double as the output payload.
    logic               out_valid_reg;
    action_t            action_reg;
    action_t            action_next;
    logic               stall_reg;
    logic               stall_next;
    record_t            rec_reg;
    record_t            rec_next;

    logic               advance;
    logic               dep;
    logic               mark;
    logic [OPCODE_W-1:0] op;
    sb_check_t          check;
    sb_ctrl_t           ctrl;

    // A beat leaves the input register whenever the result register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg    <= s_tuser[0];
            in_noop_reg   <= s_tuser[1];
            in_word_reg   <= s_tdata[31:0];
            in_eblk_reg   <= s_tdata[32];
            in_retire_reg <= s_tdata[37:33];
            in_va_reg     <= s_tdata[69:38];
            in_vb_reg     <= s_tdata[101:70];
            in_vc_reg     <= s_tdata[133:102];
        end
    end

    // Every word is checked on bits 25:21, 20:16 and 15:11, jumps included.
    assign check.reg_a = in_word_reg[25:21];
    assign check.reg_b = in_word_reg[20:16];
    assign check.reg_c = in_word_reg[15:11];
    assign op          = in_word_reg[31:26];

    // Decode and stall decision for the beat in the input register.
    always_comb
    begin
        rec_next    = rec_reg;
        stall_next  = stall_reg;
        action_next = ACT_NONE;
        mark        = 1'b0;
        if (in_cmd_reg)
        begin
            // Retire command: only the scoreboard moves.
            action_next = ACT_NONE;
        end
        else if ((in_word_reg == '0) || in_noop_reg)
        begin
            // Idle slot: a noop is forwarded only when execute can take it.
            if (in_noop_reg && !in_eblk_reg)
            begin
                action_next = ACT_NOOP;
            end
        end
        else if (in_eblk_reg)
        begin
            stall_next = 1'b1;
        end
        else if (dep)
        begin
            // Dependency stall pushes a bubble into execute.
            stall_next  = 1'b1;
            action_next = ACT_NOOP;
        end
        else
        begin
            stall_next     = 1'b0;
            action_next    = ACT_DECODE;
            rec_next.opcode = op;
            if (op <= OP_R_LAST)
            begin
                rec_next.destination  = in_word_reg[25:21];
                rec_next.operand_one  = in_vb_reg;
                rec_next.operand_two  = in_vc_reg;
                rec_next.shift_amount = in_word_reg[10:6];
                mark = (op != OP_R_NO_WB0) && (op != OP_R_NO_WB1);
            end
            else if (op <= OP_I_LAST)
            begin
                rec_next.destination = in_word_reg[25:21];
                rec_next.operand_one = in_vb_reg;
                rec_next.immediate   = in_word_reg[15:0];
                // Store and branches also read the register named as destination.
                if ((op == OP_STORE) || (op == OP_BRANCH0) || (op == OP_BRANCH1) ||
                    (op == OP_BRANCH2) || (op == OP_BRANCH3))
                begin
                    rec_next.rd_value = in_va_reg;
                end
                mark = (op < OP_I_WB_LIMIT) && (op != OP_STORE);
            end
            else if (op == OP_JUMP)
            begin
                rec_next.target_address = in_word_reg[25:0];
            end
        end
    end

    assign ctrl.mark_en    = advance && mark;
    assign ctrl.mark_reg   = in_word_reg[25:21];
    assign ctrl.retire_en  = advance && in_cmd_reg;
    assign ctrl.retire_reg = in_retire_reg;

    dss_scoreboard #(
        .PENDING_MAX (PENDING_MAX)
    ) u_scoreboard (
        .clk   (clk),
        .rst_n (rst_n),
        .check (check),
        .ctrl  (ctrl),
        .dep   (dep)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            action_reg    <= ACT_NONE;
            stall_reg     <= 1'b0;
            rec_reg       <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            action_reg    <= action_next;
            stall_reg     <= stall_next;
            rec_reg       <= rec_next;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = action_reg;
    assign m_tdata  = {5'b0, rec_reg.target_address, rec_reg.rd_value,
                       rec_reg.immediate, rec_reg.shift_amount, rec_reg.operand_two,
                       rec_reg.operand_one, rec_reg.destination, rec_reg.opcode,
                       stall_reg};

    // A delivered decode always clears the stall flag.
    `DSS_ASSERT(a_decode_unstalls, (out_valid_reg && (action_reg == ACT_DECODE)) |-> !stall_reg, "decode delivered while stalled")
    // The held record moves only when a beat enters the result register.
    `DSS_ASSERT(a_record_holds, !advance |=> $stable(rec_reg), "held record changed without a beat")
    // A retire beat sends nothing and leaves the stall flag and record alone.
    `DSS_ASSERT(a_retire_quiet, (advance && in_cmd_reg) |=> ((action_reg == ACT_NONE) && $stable(stall_reg) && $stable(rec_reg)), "retire beat disturbed the stage")

endmodule

// ----- bench/decode_stage_scoreboard_checker.sv -----
// Stream monitor that predicts and checks every result beat of the decode stage.
module decode_stage_scoreboard_checker
    import dss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // instruction[31:0], exec_blocked[32], retire_reg[37:33], value_field_a[69:38],
    // value_field_b[101:70], value_field_c[133:102], zero pad[135:134]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd[0], noop_in[1]
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // stalled[0], opcode[6:1], destination[11:7], operand_one[43:12],
    // operand_two[75:44], shift_amount[80:76], immediate[96:81],
    // rd_value[128:97], target_address[154:129], zero pad[159:155]
    input  logic [M_TDATA_W-1:0] m_tdata,
    // action[1:0]
    input  logic [M_TUSER_W-1:0] m_tuser,
    output int                   failures,
    output int                   outstanding,
    output int                   results_checked,
    output int                   decodes_seen
);

    typedef struct packed {
        action_t action;
        logic    stalled;
        record_t rec;
    } stage_result_t;

    // Shadow copy of the stage state.
    logic [2:0]    write_pending [NUM_REGS];
    record_t       held_rec;
    logic          stall_q;
    stage_result_t expected_results [$];

    function automatic bit reg_busy(input logic [REG_W-1:0] r);
        return write_pending[r] != 0;
    endfunction

    function automatic void note_write(input logic [REG_W-1:0] r);
        if (write_pending[r] < PENDING_MAX_DEF)
            write_pending[r] = write_pending[r] + 1'b1;
    endfunction

    // Applies one input beat to the shadow state and returns the result it causes.
    function automatic stage_result_t step_stage(
        input logic              retire,
        input logic [WORD_W-1:0] word,
        input logic              noop,
        input logic              eblk,
        input logic [REG_W-1:0]  rreg,
        input logic [WORD_W-1:0] va,
        input logic [WORD_W-1:0] vb,
        input logic [WORD_W-1:0] vc
    );
        stage_result_t       res;
        logic [OPCODE_W-1:0] op;
        logic                dep;
        res.action = ACT_NONE;
        op = word[31:26];
        dep = reg_busy(word[25:21]) || reg_busy(word[20:16]) || reg_busy(word[15:11]);
        if (retire) begin
            if (write_pending[rreg] != 0)
                write_pending[rreg] = write_pending[rreg] - 1'b1;
        end
        else if (word == '0 || noop) begin
            if (noop && !eblk)
                res.action = ACT_NOOP;
        end
        else if (eblk) begin
            stall_q = 1'b1;
        end
        else if (dep) begin
            stall_q = 1'b1;
            res.action = ACT_NOOP;
        end
        else begin
            held_rec.opcode = op;
            if (op <= OP_R_LAST) begin
                held_rec.destination  = word[25:21];
                held_rec.operand_one  = vb;
                held_rec.operand_two  = vc;
                held_rec.shift_amount = word[10:6];
                if (op != OP_R_NO_WB0 && op != OP_R_NO_WB1)
                    note_write(word[25:21]);
            end
            else if (op <= OP_I_LAST) begin
                held_rec.destination = word[25:21];
                held_rec.operand_one = vb;
                held_rec.immediate   = word[15:0];
                if (op == OP_STORE || op == OP_BRANCH0 || op == OP_BRANCH1 ||
                    op == OP_BRANCH2 || op == OP_BRANCH3)
                    held_rec.rd_value = va;
                if (op < OP_I_WB_LIMIT && op != OP_STORE)
                    note_write(word[25:21]);
            end
            else if (op == OP_JUMP) begin
                held_rec.target_address = word[25:0];
            end
            stall_q = 1'b0;
            res.action = ACT_DECODE;
        end
        res.stalled = stall_q;
        res.rec = held_rec;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin : monitor
        stage_result_t want;
        record_t       got_rec;
        if (!rst_n) begin
            for (int r = 0; r < NUM_REGS; r++)
                write_pending[r] = '0;
            held_rec = '0;
            stall_q = 1'b0;
            expected_results.delete();
            outstanding = 0;
        end
        else begin
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(),
                    step_stage(s_tuser[0], s_tdata[31:0], s_tuser[1],
                    s_tdata[32], s_tdata[37:33], s_tdata[69:38], s_tdata[101:70],
                    s_tdata[133:102]));
            if (m_tvalid && m_tready) begin
                got_rec = record_t'(m_tdata[154:1]);
                if (expected_results.size() == 0) begin
                    failures++;
                    $display("%0t: result beat with nothing expected, action %0d",
                             $time, m_tuser);
                end
                else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (m_tuser == ACT_DECODE)
                        decodes_seen++;
                    check_field("action", want.action, m_tuser);
                    check_field("stalled", want.stalled, m_tdata[0]);
                    check_field("opcode", want.rec.opcode, got_rec.opcode);
                    check_field("destination", want.rec.destination, got_rec.destination);
                    check_field("operand_one", want.rec.operand_one, got_rec.operand_one);
                    check_field("operand_two", want.rec.operand_two, got_rec.operand_two);
                    check_field("shift_amount", want.rec.shift_amount, got_rec.shift_amount);
                    check_field("immediate", want.rec.immediate, got_rec.immediate);
                    check_field("rd_value", want.rec.rd_value, got_rec.rd_value);
                    check_field("target_address", want.rec.target_address,
                                got_rec.target_address);
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ----- bench/tb_decode_stage_with_scoreboard.sv -----
// Top of the decode stage testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_decode_stage_with_scoreboard;
    import dss_pkg::*;

    // A run is abandoned when no beat moves on either channel for this many cycles.
    localparam int IDLE_LIMIT     = 2000;
    // The stage holds a beat in its input and result registers, so a short wait covers anything in flight.
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1225;
    // Every so many random beats the sender stops until all results are back.
    localparam int PRESSURE_EVERY = 250;

    // Opcode landmarks that the package does not name.
    localparam logic [OPCODE_W-1:0] OP_R_FIRST   = 6'd0;
    localparam logic [OPCODE_W-1:0] OP_I_FIRST   = OP_R_LAST + 1'b1;
    localparam logic [OPCODE_W-1:0] OP_I_WB_LAST = OP_I_WB_LIMIT - 1'b1;
    localparam logic [OPCODE_W-1:0] OP_TOP       = '1;

    // Receiver behavior: always ready, coin toss, mostly ready, or mostly stalled.
    typedef enum int {RX_STREAM, RX_COIN, RX_BUSY, RX_STARVED} rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int failures;
    int outstanding;
    int results_checked;
    int decodes_seen;
    int words_sent = 0;
    int retires_sent = 0;
    int drains = 0;

    rx_mode_t rx_mode = RX_STREAM;
    int       rx_left = 0;

    decode_stage_with_scoreboard i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The checker sees both channels exactly as the stage does and owns all prediction.
    decode_stage_scoreboard_checker i_scoreboard_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .failures        (failures),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .decodes_seen    (decodes_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Builds an instruction word from its opcode, three register fields and the low bits.
    function automatic logic [WORD_W-1:0] pack_word(
        input logic [OPCODE_W-1:0] op,
        input logic [REG_W-1:0]    ra,
        input logic [REG_W-1:0]    rb,
        input logic [REG_W-1:0]    rc,
        input logic [10:0]         low
    );
        return {op, ra, rb, rc, low};
    endfunction

    // Presents one beat at the falling edge and holds it until the stage takes it.
    // The valid stays high on return, so back-to-back beats never drop it.
    task automatic put_beat(
        input logic              retire,
        input logic [WORD_W-1:0] word,
        input logic              noop,
        input logic              eblk,
        input logic [REG_W-1:0]  rreg,
        input logic [WORD_W-1:0] va,
        input logic [WORD_W-1:0] vb,
        input logic [WORD_W-1:0] vc
    );
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, vc, vb, va, rreg, eblk, word};
        s_tuser <= {noop, retire};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // An instruction slot; the retire register field carries noise since it is unused.
    task automatic send_word(
        input logic [WORD_W-1:0] word,
        input logic              noop,
        input logic              eblk,
        input logic [WORD_W-1:0] va,
        input logic [WORD_W-1:0] vb,
        input logic [WORD_W-1:0] vc
    );
        put_beat(1'b0, word, noop, eblk, REG_W'($urandom_range(0, 31)), va, vb, vc);
        words_sent++;
    endtask

    // A retire command; every other field is noise that the stage must ignore.
    task automatic send_retire(input logic [REG_W-1:0] r);
        put_beat(1'b1, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r,
                 $urandom, $urandom, $urandom);
        retires_sent++;
    endtask

    task automatic sender_gap(input int cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stops sending until every result the checker is waiting for has arrived.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // One random beat. Register fields mostly come from a small pool so that writes
    // pile up on a few registers and dependency stalls happen often, while retires to
    // that same pool keep draining them. A small share of beats is pure noise.
    task automatic send_random_item();
        int                 pick;
        logic [REG_W-1:0]   ra;
        logic [REG_W-1:0]   rb;
        logic [REG_W-1:0]   rc;
        pick = $urandom_range(0, 99);
        ra = ($urandom_range(0, 4) == 0) ? REG_W'($urandom_range(0, 31))
                                          : REG_W'($urandom_range(0, 7));
        rb = ($urandom_range(0, 4) == 0) ? REG_W'($urandom_range(0, 31))
                                          : REG_W'($urandom_range(0, 7));
        rc = ($urandom_range(0, 4) == 0) ? REG_W'($urandom_range(0, 31))
                                          : REG_W'($urandom_range(0, 7));
        if (pick < 50)
            send_word(pack_word(OPCODE_W'($urandom_range(0, 63)), ra, rb, rc, 11'($urandom)),
                      1'b0, ($urandom_range(0, 9) == 0), $urandom, $urandom, $urandom);
        else if (pick < 80)
            send_retire(REG_W'($urandom_range(0, 7)));
        else if (pick < 85)
            send_retire(REG_W'($urandom_range(0, 31)));
        else if (pick < 89)
            send_word($urandom, 1'b1, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        else if (pick < 91)
            send_word('0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom, $urandom, $urandom);
        else
            send_word($urandom, ($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                      $urandom, $urandom, $urandom);
    endtask

    // The receiver switches between stall patterns for random stretches of cycles.
    always @(negedge clk)
    begin : receiver
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        else begin
            rx_left--;
        end
        case (rx_mode)
            RX_STREAM: m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_BUSY:   m_tready <= ($urandom_range(0, 7) != 0);
            default:   m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Ends the run if the handshakes stop moving, whatever the cause.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved on either channel for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int random_sent;
        int burst;
        random_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Retiring a register with no pending write must leave its count at zero.
        send_retire(5'd5);
        // Idle slots: a zero word sends nothing, a noop slot forwards a noop unless
        // execute is blocked.
        send_word('0, 1'b0, 1'b0, '1, '1, '1);
        send_word(pack_word(OP_R_FIRST, 5'd1, 5'd2, 5'd3, 11'h000), 1'b1, 1'b0, '1, '1, '1);
        send_word(pack_word(OP_R_FIRST, 5'd1, 5'd2, 5'd3, 11'h000), 1'b1, 1'b1, '1, '1, '1);
        // R-format with the largest shift amount; this one marks register 1 pending.
        send_word(pack_word(OP_R_FIRST, 5'd1, 5'd2, 5'd3, 11'h7C0), 1'b0, 1'b0,
                  '1, '1, '0);
        // The two R-format opcodes that do not write back, with the last R-format opcode between them.
        send_word(pack_word(OP_R_NO_WB0, 5'd4, 5'd5, 5'd6, 11'h03F), 1'b0, 1'b0,
                  '0, '0, '1);
        send_word(pack_word(OP_R_LAST, 5'd7, 5'd8, 5'd9, 11'h155), 1'b0, 1'b0,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_word(pack_word(OP_R_NO_WB1, 5'd31, 5'd30, 5'd29, 11'h7FF), 1'b0, 1'b0,
                  '1, '1, '1);
        // I-format: the store reads its destination value but does not write back.
        send_word(pack_word(OP_STORE, 5'd8, 5'd9, 5'd31, 11'h7FF), 1'b0, 1'b0,
                  '1, 32'h1234_5678, '0);
        send_word(pack_word(OP_I_FIRST, 5'd10, 5'd11, 5'd0, 11'h000), 1'b0, 1'b0,
                  '0, '1, '1);
        // The write-back boundary of the I-format range, from both sides.
        send_word(pack_word(OP_I_WB_LIMIT, 5'd11, 5'd12, 5'd0, 11'h2AA), 1'b0, 1'b0,
                  '0, '0, '0);
        send_word(pack_word(OP_I_WB_LAST, 5'd12, 5'd13, 5'd0, 11'h555), 1'b0, 1'b0,
                  '1, '0, '1);
        // The four branches, each taking its destination register value.
        send_word(pack_word(OP_BRANCH0, 5'd13, 5'd17, 5'd0, 11'h001), 1'b0, 1'b0,
                  32'h0000_0001, '1, '0);
        send_word(pack_word(OP_BRANCH1, 5'd14, 5'd18, 5'd0, 11'h002), 1'b0, 1'b0,
                  32'h8000_0000, '0, '1);
        send_word(pack_word(OP_BRANCH2, 5'd15, 5'd19, 5'd0, 11'h004), 1'b0, 1'b0,
                  '1, '1, '1);
        send_word(pack_word(OP_BRANCH3, 5'd16, 5'd20, 5'd0, 11'h008), 1'b0, 1'b0,
                  '0, '0, '0);
        send_word(pack_word(OP_I_LAST, 5'd21, 5'd22, 5'd23, 11'h7FF), 1'b0, 1'b0,
                  '1, '1, '1);
        // Jump with the widest target, then the top opcode that sets only the opcode.
        send_word(pack_word(OP_JUMP, 5'd31, 5'd31, 5'd31, 11'h7FF), 1'b0, 1'b0,
                  '0, '0, '0);
        send_word(pack_word(OP_TOP, 5'd31, 5'd31, 5'd31, 11'h7FF), 1'b0, 1'b0,
                  '1, '1, '1);
        // A jump whose target bits name a pending register is held back like any word.
        send_word(pack_word(OP_JUMP, 5'd7, 5'd0, 5'd0, 11'h000), 1'b0, 1'b0, '0, '0, '0);
        // Execute blocked with no dependency, then a dependency on register 1, alone
        // and together with a blocked execute stage.
        send_word(pack_word(OP_R_FIRST, 5'd2, 5'd3, 5'd4, 11'h000), 1'b0, 1'b1, '1, '1, '1);
        send_word(pack_word(OP_R_FIRST, 5'd2, 5'd1, 5'd3, 11'h000), 1'b0, 1'b0, '1, '1, '1);
        send_word(pack_word(OP_R_FIRST, 5'd2, 5'd1, 5'd3, 11'h000), 1'b0, 1'b1, '1, '1, '1);
        // Retiring register 1 lets the same word through.
        send_retire(5'd1);
        send_word(pack_word(OP_R_FIRST, 5'd2, 5'd1, 5'd3, 11'h000), 1'b0, 1'b0,
                  32'hDEAD_BEEF, 32'h0BAD_F00D, 32'hCAFE_0123);
        wait_drained();
        drains++;

        // Random part: bursts of beats with random gaps, sometimes none at all.
        while (random_sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 32);
            repeat (burst) begin
                send_random_item();
                random_sent++;
                if (random_sent % PRESSURE_EVERY == 0) begin
                    wait_drained();
                    drains++;
                end
            end
            if ($urandom_range(0, 2) != 0)
                sender_gap($urandom_range(1, 8));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d instruction beats and %0d retire beats, draining the stage %0d times.",
                 words_sent, retires_sent, drains);
        $display("Checked %0d result beats, %0d of them carrying a newly decoded instruction.",
                 results_checked, decodes_seen);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
